>>> src/block_refcount_table_core_defines.svh
// Assertion macros shared by the reference count table RTL.
// Included by the controller and datapath; depends on nothing else.
`ifndef BLOCK_REFCOUNT_TABLE_CORE_DEFINES_SVH
`define BLOCK_REFCOUNT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BRT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/brt_pkg.sv
// Package for the reference count table: sizes, request and status codes,
// entry layout and the controller/datapath command and status structs.
// No dependencies.
package brt_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KEY_W = 32;
  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request codes; the spare code behaves as a query
  localparam logic [1:0] REQ_INC   = 2'd0;
  localparam logic [1:0] REQ_DEC   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic clr;     // write an empty entry at the sweep index
    logic start;   // latch request, reset scan results
    logic rd;      // read the entry at the sweep index
    logic commit;  // write back and load the result register
  } brt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic idx_last;  // sweep index at the final entry
    logic out_busy;  // result register full and not taken this cycle
  } brt_sts_t;

endpackage

>>> src/brt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module brt_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 65,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/brt_ctrl.sv
// Controller for the reference count table: clearing pass, request intake,
// table scan and write-back sequencing. Depends on brt_pkg and the defines header.
`include "block_refcount_table_core_defines.svh"

module brt_ctrl
  import brt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_accept,
  output logic     in_ready,
  input  brt_sts_t sts,
  output brt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands from the current state
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    in_ready   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_accept;
        if (in_accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // Hold until the result register can take the new result
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BRT_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, !sts.out_busy, "commit into busy result register")
  `BRT_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_accept && in_ready, state_r == S_SCAN, "accepted request did not start a scan")
  `BRT_ASSERT_NEXT(a_scan_end, clk, rst_n, (state_r == S_SCAN) && sts.idx_last, state_r == S_DRAIN, "scan did not end at the final entry")

endmodule

>>> src/brt_dpath.sv
// Datapath for the reference count table: entry memory, sweep index, scan
// match/free tracking, write-back and result register. Depends on brt_pkg,
// brt_ram and the defines header.
`include "block_refcount_table_core_defines.svh"

module brt_dpath
  import brt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  brt_cmd_t         cmd,
  output brt_sts_t         sts,
  input  logic [1:0]       req_type,
  input  logic [KEY_W-1:0] block_number,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [CNT_W-1:0] ref_count,
  output logic             tracked,
  output logic [1:0]       status
);

  // Sweep and request registers
  logic [IDX_W-1:0] idx_r;
  logic [1:0]       req_r;
  logic [KEY_W-1:0] key_r;

  // Scan pipeline and results
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  // Result register
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_trk_r;
  logic [1:0]       out_st_r;

  // Memory ports
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  // Write-back decision
  logic             wb_we;
  logic [IDX_W-1:0] wb_idx;
  entry_t           wb_entry;
  logic [CNT_W-1:0] res_cnt;
  logic             res_trk;
  logic [1:0]       res_st;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  brt_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  assign sts.idx_last = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.out_busy = out_valid_r && !out_ready;

  // Work out the write-back and the result from the finished scan
  assign cnt_inc = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + CNT_W'(1);
  assign cnt_dec = (hit_cnt_r != '0) ? hit_cnt_r - CNT_W'(1) : '0;

  always_comb begin
    wb_we          = 1'b0;
    wb_idx         = hit_idx_r;
    wb_entry.valid = 1'b1;
    wb_entry.key   = key_r;
    wb_entry.count = cnt_inc;
    res_cnt        = '0;
    res_trk        = 1'b0;
    res_st         = STAT_NOT_FOUND;
    case (req_r)
      REQ_INC: begin
        if (hit_r) begin
          wb_we   = 1'b1;
          res_cnt = cnt_inc;
          res_trk = 1'b1;
          res_st  = STAT_OK;
        end else if (free_r) begin
          // Claim the lowest free slot with a count of one
          wb_we          = 1'b1;
          wb_idx         = free_idx_r;
          wb_entry.count = CNT_W'(1);
          res_cnt        = CNT_W'(1);
          res_trk        = 1'b1;
          res_st         = STAT_OK;
        end else begin
          res_st = STAT_FULL;
        end
      end
      REQ_DEC: begin
        if (hit_r) begin
          // Release the slot once the count is zero
          wb_we          = 1'b1;
          wb_entry.valid = (cnt_dec != '0);
          wb_entry.count = cnt_dec;
          res_cnt        = cnt_dec;
          res_trk        = (cnt_dec != '0);
          res_st         = STAT_OK;
        end
      end
      default: begin
        if (hit_r) begin
          res_cnt = hit_cnt_r;
          res_trk = 1'b1;
          res_st  = STAT_OK;
        end
      end
    endcase
  end

  // Memory write: clearing sweep or write-back
  assign ram_we    = cmd.clr || (cmd.commit && wb_we);
  assign ram_waddr = cmd.clr ? idx_r : wb_idx;
  assign ram_wdata = cmd.clr ? ENTRY_W'(0) : ENTRY_W'(wb_entry);

  // Sweep index, scan flags and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd;
      if (cmd.start) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else begin
        if (cmd.clr || cmd.rd) begin
          idx_r <= sts.idx_last ? '0 : idx_r + IDX_W'(1);
        end
        if (cmp_vld_r) begin
          if (rd_entry.valid) begin
            if (!hit_r && (rd_entry.key == key_r)) begin
              hit_r <= 1'b1;
            end
          end else if (!free_r) begin
            free_r <= 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= req_type;
      key_r <= block_number;
    end
    if (cmd.rd) begin
      cmp_idx_r <= idx_r;
    end
    if (cmp_vld_r) begin
      if (rd_entry.valid) begin
        if (!hit_r && (rd_entry.key == key_r)) begin
          hit_idx_r <= cmp_idx_r;
          hit_cnt_r <= rd_entry.count;
        end
      end else if (!free_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.commit) begin
      out_cnt_r <= res_cnt;
      out_trk_r <= res_trk;
      out_st_r  <= res_st;
    end
  end

  assign out_valid = out_valid_r;
  assign ref_count = out_cnt_r;
  assign tracked   = out_trk_r;
  assign status    = out_st_r;

  `BRT_ASSERT_NOW(a_commit_idle, clk, rst_n, cmd.commit, !cmp_vld_r && !cmd.rd, "write-back during scan")
  `BRT_ASSERT_NEXT(a_start_flags, clk, rst_n, cmd.start, !hit_r && !free_r, "scan flags not reset at start")
  `BRT_ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid_r, "result not presented after commit")

endmodule

>>> src/block_refcount_table_core.sv
// Top level of the block reference count table.
// Depends on brt_pkg, brt_ctrl, brt_dpath and brt_ram.
//
// Usage:
//   Input channel (in_*): one request per transaction, the operation code in
//   in_tuser and the block number key in in_tdata. Output channel (out_*): one
//   result per request with the count, tracked flag and status.
//   Each request scans every table entry once through the single read port of
//   the entry memory, then writes back at most once. A request occupies the
//   block through the scan, drain and update states; the result register is
//   loaded when the update commits. One request is in flight at a time.
//   After reset the block sweeps the entry memory to empty it, one entry per
//   cycle; in_tready stays low meanwhile.
//   The result sits in an output register, so the next request is accepted
//   while the previous result waits; if the receiver still holds off when the
//   next result is ready, the block holds that result until the register
//   frees up.
module block_refcount_table_core
  import brt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] block_number
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] ref_count, [32] tracked, [34:33] status, zero pad
);

  brt_cmd_t         cmd;
  brt_sts_t         sts;
  logic             in_accept;
  logic [CNT_W-1:0] ref_count;
  logic             tracked;
  logic [1:0]       status;

  assign in_accept = in_tvalid && in_tready;

  brt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_ready  (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brt_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_tuser),
    .block_number (in_tdata),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .ref_count    (ref_count),
    .tracked      (tracked),
    .status       (status)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {5'b0, status, tracked, ref_count};

endmodule
